>>> hw/rtl/lbcm_pkg.sv
// ----------------------------------------------------------------------------
// lbcm_pkg
// Shared types, codes and reset constants of the LRU buffer cache manager.
// ----------------------------------------------------------------------------
package lbcm_pkg;

  // default sizing
  localparam int SLOTS_DEF     = 256;
  localparam int MAX_BLOCK_DEF = 65536;

  // field widths
  localparam int REQ_W   = 4;
  localparam int FILE_W  = 16;
  localparam int BLOCK_W = 40;
  localparam int SIZE_W  = 17;
  localparam int SLOT_W  = 8;
  localparam int FLAG_W  = 3;
  localparam int STAT_W  = 3;
  localparam int USE_W   = 8;
  localparam int EV_W    = 9;
  localparam int EMARK_W = 9;
  localparam int BMARK_W = 25;
  localparam int CFGI_W  = 3;
  localparam int CFGD_W  = 25;

  // register reset values
  localparam logic [EMARK_W-1:0] ENTRIES_HIGH_RST = EMARK_W'(140);
  localparam logic [EMARK_W-1:0] ENTRIES_LOW_RST  = EMARK_W'(128);
  localparam logic [BMARK_W-1:0] BYTES_HIGH_RST   = BMARK_W'(1536 * 1024);
  localparam logic [BMARK_W-1:0] BYTES_LOW_RST    = BMARK_W'(1024 * 1024);

  // register indexes
  localparam logic [CFGI_W-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CFGI_W-1:0] CFG_ENTRY_HIGH = 3'd1;
  localparam logic [CFGI_W-1:0] CFG_ENTRY_LOW  = 3'd2;
  localparam logic [CFGI_W-1:0] CFG_BYTE_HIGH  = 3'd3;
  localparam logic [CFGI_W-1:0] CFG_BYTE_LOW   = 3'd4;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ACQUIRE    = 4'd0;
  localparam logic [REQ_W-1:0] REQ_REF        = 4'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE    = 4'd2;
  localparam logic [REQ_W-1:0] REQ_INVALIDATE = 4'd3;
  localparam logic [REQ_W-1:0] REQ_SET_FLAGS  = 4'd4;
  localparam logic [REQ_W-1:0] REQ_CLR_FLAGS  = 4'd5;
  localparam logic [REQ_W-1:0] REQ_TOUCH      = 4'd6;
  localparam logic [REQ_W-1:0] REQ_REM_FILE   = 4'd7;
  localparam logic [REQ_W-1:0] REQ_REM_ALL    = 4'd8;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BUSY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_SLOT  = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_SLOT = 3'd3;
  localparam logic [STAT_W-1:0] ST_USE_ERR  = 3'd4;
  localparam logic [STAT_W-1:0] ST_DISABLED = 3'd5;

  localparam int WLOCK_BIT = 2;

  typedef struct packed {
    logic [FILE_W-1:0]  file;
    logic [BLOCK_W-1:0] block;
    logic [SIZE_W-1:0]  size;
    logic [USE_W-1:0]   use_cnt;
    logic [FLAG_W-1:0]  flags;
  } entry_t;

  typedef enum logic [0:0] {
    OP_MOVE,
    OP_DROP
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_LK_CHK,
    S_MISS,
    S_EV,
    S_EV_CHK,
    S_FREE,
    S_SL_OP,
    S_UL_P,
    S_UL_PW,
    S_UL_N,
    S_UL_NW,
    S_DROP,
    S_PH,
    S_PH_W,
    S_WR_CUR,
    S_SCAN,
    S_SCAN_CHK,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/lbcm_if.sv
// ----------------------------------------------------------------------------
// lbcm_if
// Request and response channels of the buffer cache manager.
// ----------------------------------------------------------------------------
interface lbcm_req_if;
  logic                          valid;
  logic                          ready;
  logic [lbcm_pkg::REQ_W-1:0]    req_type;
  logic [lbcm_pkg::FILE_W-1:0]   file_id;
  logic [lbcm_pkg::BLOCK_W-1:0]  phys_block;
  logic [lbcm_pkg::SIZE_W-1:0]   block_size;
  logic [lbcm_pkg::SLOT_W-1:0]   slot;
  logic [lbcm_pkg::FLAG_W-1:0]   flag_mask;

  modport source (output valid, req_type, file_id, phys_block, block_size, slot, flag_mask,
                  input ready);
  modport sink (input valid, req_type, file_id, phys_block, block_size, slot, flag_mask,
                output ready);
endinterface

interface lbcm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lbcm_pkg::STAT_W-1:0]  status;
  logic                         hit;
  logic [lbcm_pkg::SLOT_W-1:0]  entry_slot;
  logic [lbcm_pkg::USE_W-1:0]   use_count_out;
  logic [lbcm_pkg::FLAG_W-1:0]  flags_out;
  logic [lbcm_pkg::EV_W-1:0]    evicted;

  modport source (output valid, status, hit, entry_slot, use_count_out, flags_out, evicted,
                  input ready);
  modport sink (input valid, status, hit, entry_slot, use_count_out, flags_out, evicted,
                output ready);
endinterface

>>> hw/rtl/lbcm_ram.sv
// ----------------------------------------------------------------------------
// lbcm_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module lbcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hw/rtl/lru_buffer_cache_manager.sv
// ----------------------------------------------------------------------------
// lru_buffer_cache_manager
// Tag manager of a block-buffer cache kept in LRU order, with watermark
// eviction from the list tail. Entries and list links live in one RAM.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          item
//  req      in   valid/ready        request: type, file, block, size, slot, mask
//  rsp      out  valid/ready        result: status, hit, slot, use, flags, evicted
//  cfg      in   cfg_we only        register write: cfg_index, cfg_wdata
//
//  One item at a time: a request is taken only while the sequencer is idle.
//  Each item is accepted, dispatched and finished; in between, an acquire
//  lookup walks the list, eviction tests candidates from the tail, entries
//  are unlinked or moved through the single RAM port, the free-slot search
//  takes one 32-slot chunk at a time and the remove scans visit each slot.
//  Reset: valid bits, list head/tail and counters clear and registers load
//  their reset values at once; no clearing pass. A waiting result lets the
//  next item in, but that item cannot finish until the result is taken.
module lru_buffer_cache_manager #(
  parameter int SLOTS           = lbcm_pkg::SLOTS_DEF,
  parameter int MAX_BLOCK_BYTES = lbcm_pkg::MAX_BLOCK_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  lbcm_req_if.sink                     req,
  lbcm_rsp_if.source                   rsp,
  input  logic                         cfg_we,
  input  logic [lbcm_pkg::CFGI_W-1:0]  cfg_index,
  input  logic [lbcm_pkg::CFGD_W-1:0]  cfg_wdata
);

  localparam int SW    = $clog2(SLOTS);                 // slot pointer width
  localparam int ETW   = $clog2(SLOTS + 1);             // entry count width
  localparam int CMPE  = ((ETW > lbcm_pkg::EMARK_W) ? ETW : lbcm_pkg::EMARK_W) + 1;
  localparam int BTW   = ((SW + lbcm_pkg::SIZE_W > lbcm_pkg::BMARK_W) ?
                          SW + lbcm_pkg::SIZE_W : lbcm_pkg::BMARK_W) + 1;
  localparam int PW    = $bits(lbcm_pkg::entry_t);
  localparam int RW    = PW + 2 * SW;                   // {prev, next, payload}
  localparam int CH    = 32;                            // free-search chunk
  localparam int NCH   = (SLOTS + CH - 1) / CH;
  localparam int CCW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int EV_MAX = (1 << lbcm_pkg::EV_W) - 1;
  localparam logic [lbcm_pkg::USE_W-1:0] USE1 = lbcm_pkg::USE_W'(1);

  // --- configuration registers ---
  logic                          cfg_en;
  logic [lbcm_pkg::EMARK_W-1:0]  ehigh, elow;
  logic [lbcm_pkg::BMARK_W-1:0]  bhigh, blow;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_en <= 1'b1;
      ehigh  <= lbcm_pkg::ENTRIES_HIGH_RST;
      elow   <= lbcm_pkg::ENTRIES_LOW_RST;
      bhigh  <= lbcm_pkg::BYTES_HIGH_RST;
      blow   <= lbcm_pkg::BYTES_LOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lbcm_pkg::CFG_ENABLE:     cfg_en <= cfg_wdata[0];
        lbcm_pkg::CFG_ENTRY_HIGH: ehigh  <= cfg_wdata[lbcm_pkg::EMARK_W-1:0];
        lbcm_pkg::CFG_ENTRY_LOW:  elow   <= cfg_wdata[lbcm_pkg::EMARK_W-1:0];
        lbcm_pkg::CFG_BYTE_HIGH:  bhigh  <= cfg_wdata;
        lbcm_pkg::CFG_BYTE_LOW:   blow   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --- state ---
  lbcm_pkg::state_t state, state_next;
  lbcm_pkg::op_t    op;

  logic [SLOTS-1:0] valid;
  logic [SW-1:0]    head, tail;
  logic [ETW-1:0]   entry_total;
  logic [BTW-1:0]   byte_total;

  // latched request
  logic [lbcm_pkg::REQ_W-1:0]   r_req;
  logic [lbcm_pkg::FILE_W-1:0]  r_file;
  logic [lbcm_pkg::BLOCK_W-1:0] r_block;
  logic [lbcm_pkg::SIZE_W-1:0]  r_size;
  logic [lbcm_pkg::SLOT_W-1:0]  r_slot;
  logic [lbcm_pkg::FLAG_W-1:0]  r_mask;

  // working entry and walk state
  lbcm_pkg::entry_t cur;
  logic [SW-1:0]    cur_s, cur_prev, cur_next;
  logic [SW-1:0]    lk_s;
  logic [ETW-1:0]   lk_cnt;
  logic [SW:0]      scan_s;
  logic [CCW-1:0]   chunk;
  logic             r_insert;

  // result being built, and the output register
  logic [lbcm_pkg::STAT_W-1:0] res_status;
  logic                        res_hit;
  logic [lbcm_pkg::SLOT_W-1:0] res_slot;
  logic [lbcm_pkg::USE_W-1:0]  res_use;
  logic [lbcm_pkg::FLAG_W-1:0] res_flags;
  logic [ETW-1:0]              res_ev;

  logic                        out_valid;
  logic [lbcm_pkg::STAT_W-1:0] out_status;
  logic                        out_hit;
  logic [lbcm_pkg::SLOT_W-1:0] out_slot;
  logic [lbcm_pkg::USE_W-1:0]  out_use;
  logic [lbcm_pkg::FLAG_W-1:0] out_flags;
  logic [lbcm_pkg::EV_W-1:0]   out_ev;

  // --- entry RAM ---
  logic          ram_we, ram_re;
  logic [SW-1:0] ram_addr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  lbcm_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  lbcm_pkg::entry_t rd_e;
  logic [SW-1:0]    rd_prev, rd_next;
  assign {rd_prev, rd_next, rd_e} = ram_rdata;

  // slot request applied to the entry just read
  lbcm_pkg::entry_t sl_e;
  logic             sl_drop;

  always_comb begin
    sl_e = rd_e;
    case (r_req)
      lbcm_pkg::REQ_REF: begin
        if (rd_e.use_cnt != '1) sl_e.use_cnt = rd_e.use_cnt + USE1;
      end
      lbcm_pkg::REQ_RELEASE: begin
        if (rd_e.use_cnt != '0) sl_e.use_cnt = rd_e.use_cnt - USE1;
      end
      lbcm_pkg::REQ_SET_FLAGS: sl_e.flags = rd_e.flags | r_mask;
      lbcm_pkg::REQ_CLR_FLAGS: sl_e.flags = rd_e.flags & ~r_mask;
      default: ;
    endcase
  end

  assign sl_drop = (r_req == lbcm_pkg::REQ_INVALIDATE) && (rd_e.use_cnt <= USE1);

  // --- decisions ---
  logic [SW-1:0] slot_idx, scan_idx;
  logic          slot_ok, lk_match, lk_last, ev_need, ev_stop, miss_evict;
  logic          scan_end, scan_hit;

  assign slot_idx = SW'(r_slot);
  assign scan_idx = scan_s[SW-1:0];
  assign slot_ok  = (32'(r_slot) < 32'(SLOTS)) && valid[slot_idx];
  assign lk_match = (rd_e.file == r_file) && (rd_e.block == r_block) &&
                    (rd_e.size >= r_size);
  assign lk_last  = (ETW'(lk_cnt + ETW'(1)) == entry_total);
  assign ev_need  = (entry_total != '0) &&
                    ((CMPE'(entry_total) > CMPE'(elow)) ||
                     (byte_total > BTW'(blow)));
  assign ev_stop  = (rd_e.use_cnt != '0) || rd_e.flags[lbcm_pkg::WLOCK_BIT];
  assign miss_evict = ((byte_total + BTW'(r_size)) > BTW'(bhigh)) ||
                      ((CMPE'(entry_total) + CMPE'(1)) >= CMPE'(ehigh));
  assign scan_end = (scan_s == (SW+1)'(SLOTS));
  assign scan_hit = (r_req == lbcm_pkg::REQ_REM_ALL) || (rd_e.file == r_file);

  // free-slot search, one 32-slot chunk a cycle; padding reads as taken
  logic [NCH*CH-1:0] valid_pad;
  logic [CH-1:0]     chunk_bits;
  logic [4:0]        free_pos;
  logic              free_found, chunk_last;
  logic [SW-1:0]     free_s;

  always_comb begin
    valid_pad = '1;
    valid_pad[SLOTS-1:0] = valid;
    chunk_bits = valid_pad[chunk*CH +: CH];
    free_pos = '0;
    for (int i = CH - 1; i >= 0; i--) begin
      if (!chunk_bits[i]) begin
        free_pos = 5'(i);
      end
    end
  end

  assign free_found = ~&chunk_bits;
  assign chunk_last = (chunk == CCW'(NCH - 1));
  assign free_s     = SW'({chunk, free_pos});

  // where the eviction loop hands over
  lbcm_pkg::state_t ev_exit;
  assign ev_exit = (r_req == lbcm_pkg::REQ_ACQUIRE) ? lbcm_pkg::S_FREE : lbcm_pkg::S_DONE;

  logic out_free;
  assign out_free = !out_valid || rsp.ready;

  // --- next state and RAM control ---
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = cur_s;
    ram_wdata  = {cur_prev, cur_next, cur};
    case (state)
      lbcm_pkg::S_IDLE: begin
        if (req.valid) state_next = lbcm_pkg::S_DISPATCH;
      end
      lbcm_pkg::S_DISPATCH: begin
        case (r_req)
          lbcm_pkg::REQ_ACQUIRE: begin
            if (!cfg_en) begin
              state_next = lbcm_pkg::S_DONE;
            end else if (entry_total == '0) begin
              state_next = lbcm_pkg::S_MISS;
            end else begin
              ram_re     = 1'b1;
              ram_addr   = head;
              state_next = lbcm_pkg::S_LK_CHK;
            end
          end
          lbcm_pkg::REQ_REF, lbcm_pkg::REQ_RELEASE, lbcm_pkg::REQ_INVALIDATE,
          lbcm_pkg::REQ_SET_FLAGS, lbcm_pkg::REQ_CLR_FLAGS, lbcm_pkg::REQ_TOUCH: begin
            if (slot_ok) begin
              ram_re     = 1'b1;
              ram_addr   = slot_idx;
              state_next = lbcm_pkg::S_SL_OP;
            end else begin
              state_next = lbcm_pkg::S_DONE;
            end
          end
          lbcm_pkg::REQ_REM_FILE, lbcm_pkg::REQ_REM_ALL: state_next = lbcm_pkg::S_SCAN;
          default: state_next = lbcm_pkg::S_DONE;
        endcase
      end
      lbcm_pkg::S_LK_CHK: begin
        if (lk_match) begin
          if (rd_e.use_cnt != '0)  state_next = lbcm_pkg::S_DONE;
          else if (lk_s == head)   state_next = lbcm_pkg::S_WR_CUR;
          else                     state_next = lbcm_pkg::S_UL_P;
        end else if (lk_last) begin
          state_next = lbcm_pkg::S_MISS;
        end else begin
          ram_re   = 1'b1;
          ram_addr = rd_next;
        end
      end
      lbcm_pkg::S_MISS: begin
        state_next = miss_evict ? lbcm_pkg::S_EV : lbcm_pkg::S_FREE;
      end
      lbcm_pkg::S_EV: begin
        if (ev_need) begin
          ram_re     = 1'b1;
          ram_addr   = tail;
          state_next = lbcm_pkg::S_EV_CHK;
        end else begin
          state_next = ev_exit;
        end
      end
      lbcm_pkg::S_EV_CHK: begin
        state_next = ev_stop ? ev_exit : lbcm_pkg::S_UL_P;
      end
      lbcm_pkg::S_FREE: begin
        if (free_found)      state_next = lbcm_pkg::S_PH;
        else if (chunk_last) state_next = lbcm_pkg::S_DONE;
      end
      lbcm_pkg::S_SL_OP: begin
        case (r_req)
          lbcm_pkg::REQ_REF:
            state_next = (rd_e.use_cnt == '1) ? lbcm_pkg::S_DONE : lbcm_pkg::S_WR_CUR;
          lbcm_pkg::REQ_RELEASE:
            state_next = (rd_e.use_cnt == '0) ? lbcm_pkg::S_DONE : lbcm_pkg::S_WR_CUR;
          lbcm_pkg::REQ_INVALIDATE:
            state_next = (rd_e.use_cnt > USE1) ? lbcm_pkg::S_DONE : lbcm_pkg::S_UL_P;
          lbcm_pkg::REQ_SET_FLAGS, lbcm_pkg::REQ_CLR_FLAGS:
            state_next = lbcm_pkg::S_WR_CUR;
          lbcm_pkg::REQ_TOUCH:
            state_next = (slot_idx == head) ? lbcm_pkg::S_DONE : lbcm_pkg::S_UL_P;
          default: state_next = lbcm_pkg::S_DONE;
        endcase
      end
      lbcm_pkg::S_UL_P: begin
        if (cur_s == head) begin
          state_next = lbcm_pkg::S_UL_N;
        end else begin
          ram_re     = 1'b1;
          ram_addr   = cur_prev;
          state_next = lbcm_pkg::S_UL_PW;
        end
      end
      lbcm_pkg::S_UL_PW: begin
        ram_we     = 1'b1;
        ram_addr   = cur_prev;
        ram_wdata  = {rd_prev, cur_next, rd_e};
        state_next = lbcm_pkg::S_UL_N;
      end
      lbcm_pkg::S_UL_N: begin
        if (cur_s == tail) begin
          state_next = (op == lbcm_pkg::OP_DROP) ? lbcm_pkg::S_DROP : lbcm_pkg::S_PH;
        end else begin
          ram_re     = 1'b1;
          ram_addr   = cur_next;
          state_next = lbcm_pkg::S_UL_NW;
        end
      end
      lbcm_pkg::S_UL_NW: begin
        ram_we     = 1'b1;
        ram_addr   = cur_next;
        ram_wdata  = {cur_prev, rd_next, rd_e};
        state_next = (op == lbcm_pkg::OP_DROP) ? lbcm_pkg::S_DROP : lbcm_pkg::S_PH;
      end
      lbcm_pkg::S_DROP: begin
        case (r_req)
          lbcm_pkg::REQ_ACQUIRE, lbcm_pkg::REQ_RELEASE: state_next = lbcm_pkg::S_EV;
          lbcm_pkg::REQ_REM_FILE, lbcm_pkg::REQ_REM_ALL: state_next = lbcm_pkg::S_SCAN;
          default: state_next = lbcm_pkg::S_DONE;
        endcase
      end
      lbcm_pkg::S_PH: begin
        if (entry_total == '0) begin
          state_next = lbcm_pkg::S_WR_CUR;
        end else begin
          ram_re     = 1'b1;
          ram_addr   = head;
          state_next = lbcm_pkg::S_PH_W;
        end
      end
      lbcm_pkg::S_PH_W: begin
        ram_we     = 1'b1;
        ram_addr   = head;
        ram_wdata  = {cur_s, rd_next, rd_e};
        state_next = lbcm_pkg::S_WR_CUR;
      end
      lbcm_pkg::S_WR_CUR: begin
        ram_we     = 1'b1;
        state_next = (r_req == lbcm_pkg::REQ_RELEASE) ? lbcm_pkg::S_EV : lbcm_pkg::S_DONE;
      end
      lbcm_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = lbcm_pkg::S_DONE;
        end else if (valid[scan_idx]) begin
          ram_re     = 1'b1;
          ram_addr   = scan_idx;
          state_next = lbcm_pkg::S_SCAN_CHK;
        end
      end
      lbcm_pkg::S_SCAN_CHK: begin
        state_next = scan_hit ? lbcm_pkg::S_UL_P : lbcm_pkg::S_SCAN;
      end
      lbcm_pkg::S_DONE: begin
        if (out_free) state_next = lbcm_pkg::S_IDLE;
      end
      default: state_next = lbcm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lbcm_pkg::S_IDLE;
    else     state <= state_next;
  end

  assign req.ready = (state == lbcm_pkg::S_IDLE);

  // --- control registers ---
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      head        <= '0;
      tail        <= '0;
      entry_total <= '0;
      byte_total  <= '0;
    end else begin
      case (state)
        lbcm_pkg::S_UL_P: begin
          if (cur_s == head) head <= cur_next;
        end
        lbcm_pkg::S_UL_N: begin
          if (cur_s == tail) tail <= cur_prev;
        end
        lbcm_pkg::S_DROP: begin
          valid[cur_s] <= 1'b0;
          entry_total  <= entry_total - ETW'(1);
          byte_total   <= byte_total - BTW'(cur.size);
        end
        lbcm_pkg::S_PH: begin
          if (entry_total == '0) begin
            head <= cur_s;
            tail <= cur_s;
          end
        end
        lbcm_pkg::S_PH_W: head <= cur_s;
        lbcm_pkg::S_WR_CUR: begin
          if (r_insert) begin
            valid[cur_s] <= 1'b1;
            entry_total  <= entry_total + ETW'(1);
            byte_total   <= byte_total + BTW'(cur.size);
          end
        end
        default: ;
      endcase
    end
  end

  // --- datapath: request, working entry, result ---
  always_ff @(posedge clk) begin
    case (state)
      lbcm_pkg::S_IDLE: begin
        if (req.valid) begin
          r_req   <= req.req_type;
          r_file  <= req.file_id;
          r_block <= req.phys_block;
          r_size  <= (32'(req.block_size) > 32'(MAX_BLOCK_BYTES)) ?
                     lbcm_pkg::SIZE_W'(MAX_BLOCK_BYTES) : req.block_size;
          r_slot  <= req.slot;
          r_mask  <= req.flag_mask;
          r_insert   <= 1'b0;
          res_status <= lbcm_pkg::ST_OK;
          res_hit    <= 1'b0;
          res_slot   <= '0;
          res_use    <= '0;
          res_flags  <= '0;
          res_ev     <= '0;
        end
      end
      lbcm_pkg::S_DISPATCH: begin
        lk_s   <= head;
        lk_cnt <= '0;
        scan_s <= '0;
        chunk  <= '0;
        case (r_req)
          lbcm_pkg::REQ_ACQUIRE: begin
            if (!cfg_en) res_status <= lbcm_pkg::ST_DISABLED;
          end
          lbcm_pkg::REQ_REF, lbcm_pkg::REQ_RELEASE, lbcm_pkg::REQ_INVALIDATE,
          lbcm_pkg::REQ_SET_FLAGS, lbcm_pkg::REQ_CLR_FLAGS, lbcm_pkg::REQ_TOUCH: begin
            res_slot <= r_slot;
            if (!slot_ok) res_status <= lbcm_pkg::ST_BAD_SLOT;
          end
          default: ;
        endcase
      end
      lbcm_pkg::S_LK_CHK: begin
        if (lk_match) begin
          // a busy hit ends here, so the working copy only matters when free
          cur        <= {rd_e.file, rd_e.block, rd_e.size, USE1, rd_e.flags};
          cur_prev   <= rd_prev;
          cur_next   <= rd_next;
          cur_s      <= lk_s;
          op         <= lbcm_pkg::OP_MOVE;
          res_hit    <= 1'b1;
          res_slot   <= lbcm_pkg::SLOT_W'(lk_s);
          res_flags  <= rd_e.flags;
          if (rd_e.use_cnt != '0) begin
            res_status <= lbcm_pkg::ST_BUSY;
            res_use    <= rd_e.use_cnt;
          end else begin
            res_use    <= USE1;
          end
        end else begin
          lk_s   <= rd_next;
          lk_cnt <= ETW'(lk_cnt + ETW'(1));
        end
      end
      lbcm_pkg::S_EV_CHK: begin
        if (!ev_stop) begin
          cur      <= rd_e;
          cur_prev <= rd_prev;
          cur_next <= rd_next;
          cur_s    <= tail;
          op       <= lbcm_pkg::OP_DROP;
          res_ev   <= res_ev + ETW'(1);
        end
      end
      lbcm_pkg::S_FREE: begin
        if (free_found) begin
          cur.file    <= r_file;
          cur.block   <= r_block;
          cur.size    <= r_size;
          cur.use_cnt <= USE1;
          cur.flags   <= r_mask;
          cur_s       <= free_s;
          r_insert    <= 1'b1;
          res_slot    <= lbcm_pkg::SLOT_W'(free_s);
          res_use     <= USE1;
          res_flags   <= r_mask;
        end else if (chunk_last) begin
          res_status <= lbcm_pkg::ST_NO_SLOT;
        end else begin
          chunk <= chunk + CCW'(1);
        end
      end
      lbcm_pkg::S_SL_OP: begin
        cur       <= sl_e;
        cur_prev  <= rd_prev;
        cur_next  <= rd_next;
        cur_s     <= slot_idx;
        res_use   <= sl_drop ? '0 : sl_e.use_cnt;
        res_flags <= sl_drop ? '0 : sl_e.flags;
        case (r_req)
          lbcm_pkg::REQ_REF: begin
            if (rd_e.use_cnt == '1) res_status <= lbcm_pkg::ST_USE_ERR;
          end
          lbcm_pkg::REQ_RELEASE: begin
            if (rd_e.use_cnt == '0) res_status <= lbcm_pkg::ST_USE_ERR;
          end
          lbcm_pkg::REQ_INVALIDATE: begin
            if (sl_drop) begin
              op     <= lbcm_pkg::OP_DROP;
              res_ev <= ETW'(1);
            end else begin
              res_status <= lbcm_pkg::ST_BUSY;
            end
          end
          default: op <= lbcm_pkg::OP_MOVE;
        endcase
      end
      lbcm_pkg::S_DROP: begin
        // a release whose own entry went in the eviction reports nothing
        if (r_req == lbcm_pkg::REQ_RELEASE && cur_s == slot_idx) begin
          res_use   <= '0;
          res_flags <= '0;
        end
        if (r_req == lbcm_pkg::REQ_REM_FILE || r_req == lbcm_pkg::REQ_REM_ALL) begin
          scan_s <= scan_s + (SW+1)'(1);
        end
      end
      lbcm_pkg::S_PH: begin
        if (entry_total == '0) cur_prev <= cur_s;
      end
      lbcm_pkg::S_PH_W: begin
        cur_next <= head;
        cur_prev <= cur_s;
      end
      lbcm_pkg::S_SCAN: begin
        if (!scan_end && !valid[scan_idx]) scan_s <= scan_s + (SW+1)'(1);
      end
      lbcm_pkg::S_SCAN_CHK: begin
        if (scan_hit) begin
          cur      <= rd_e;
          cur_prev <= rd_prev;
          cur_next <= rd_next;
          cur_s    <= scan_idx;
          op       <= lbcm_pkg::OP_DROP;
          res_ev   <= res_ev + ETW'(1);
        end else begin
          scan_s <= scan_s + (SW+1)'(1);
        end
      end
      default: ;
    endcase
  end

  // --- output register ---
  logic load_out;
  assign load_out = (state == lbcm_pkg::S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_hit    <= res_hit;
      out_slot   <= res_slot;
      out_use    <= res_use;
      out_flags  <= res_flags;
      out_ev     <= (32'(res_ev) > 32'(EV_MAX)) ? lbcm_pkg::EV_W'(EV_MAX) :
                                                   lbcm_pkg::EV_W'(res_ev);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.hit           = out_hit;
  assign rsp.entry_slot    = out_slot;
  assign rsp.use_count_out = out_use;
  assign rsp.flags_out     = out_flags;
  assign rsp.evicted       = out_ev;

`ifndef SYNTHESIS
  a_total_matches_valid: assert property (@(posedge clk) disable iff (rst)
    entry_total == ETW'($countones(valid)))
    else $error("entry count differs from valid bits");

  a_empty_no_bytes: assert property (@(posedge clk) disable iff (rst)
    entry_total == '0 |-> byte_total == '0)
    else $error("byte total nonzero with no entries");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != lbcm_pkg::S_IDLE)
    else $error("item accepted but sequencer stayed idle");

  a_done_loads_out: assert property (@(posedge clk) disable iff (rst)
    load_out |=> rsp.valid && state == lbcm_pkg::S_IDLE)
    else $error("finished item not presented");

  a_ram_one_access: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ram_re && $past(state) != lbcm_pkg::S_IDLE)
    else $error("RAM write clashes with read or follows idle");
`endif

endmodule

>>> dv/lbcm_checker.sv
// ----------------------------------------------------------------------------
// lbcm_checker
// Watches the request, response and register ports of the buffer cache
// manager, predicts each response from its own copy of the tag store and
// compares field by field in arrival order.
// ----------------------------------------------------------------------------
module lbcm_checker (
  input  logic                         clk,
  input  logic                         rst,
  lbcm_req_if                          req,
  lbcm_rsp_if                          rsp,
  input  logic                         cfg_we,
  input  logic [lbcm_pkg::CFGI_W-1:0]  cfg_index,
  input  logic [lbcm_pkg::CFGD_W-1:0]  cfg_wdata,
  output int                           fail_count,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lbcm_pkg::*;

  localparam int NS = SLOTS_DEF;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [USE_W-1:0]  use_cnt;
    logic [FLAG_W-1:0] flags;
    logic [EV_W-1:0]   ev;
  } result_t;

  result_t expected_q[$];

  // configuration copy
  logic               en;
  logic [EMARK_W-1:0] ent_hi, ent_lo;
  logic [BMARK_W-1:0] byt_hi, byt_lo;

  // tag store copy
  logic               tag_ok [NS];
  logic [FILE_W-1:0]  tag_file [NS];
  logic [BLOCK_W-1:0] tag_blk [NS];
  int                 tag_size [NS];
  int                 tag_use [NS];
  logic [FLAG_W-1:0]  tag_flags [NS];
  int                 prv [NS];
  int                 nxt [NS];
  int                 head, tail, n_entries;
  longint             n_bytes;

  function automatic void unlink(int s);
    int p, n;
    p = prv[s];
    n = nxt[s];
    if (s == head) head = n; else nxt[p] = n;
    if (s == tail) tail = p; else prv[n] = p;
  endfunction

  function automatic void push_head(int s);
    if (n_entries == 0) begin
      head = s;
      tail = s;
    end else begin
      nxt[s] = head;
      prv[head] = s;
      head = s;
    end
    prv[s] = s;
  endfunction

  function automatic void drop(int s);
    unlink(s);
    tag_ok[s] = 1'b0;
    n_entries--;
    n_bytes -= tag_size[s];
  endfunction

  // evict unused, unlocked entries from the tail down to the low marks
  function automatic int trim_to_low();
    int n, t;
    n = 0;
    while (n_entries > 0 && (n_entries > ent_lo || n_bytes > byt_lo)) begin
      t = tail;
      if (tag_use[t] != 0 || tag_flags[t][WLOCK_BIT]) break;
      drop(t);
      n++;
    end
    return n;
  endfunction

  function automatic int purge(bit all, logic [FILE_W-1:0] f);
    int n;
    n = 0;
    for (int s = 0; s < NS; s++)
      if (tag_ok[s] && (all || tag_file[s] == f)) begin
        drop(s);
        n++;
      end
    return n;
  endfunction

  function automatic result_t cache_step(logic [REQ_W-1:0] op, logic [FILE_W-1:0] f,
                                         logic [BLOCK_W-1:0] b, logic [SIZE_W-1:0] sz_in,
                                         logic [SLOT_W-1:0] sl, logic [FLAG_W-1:0] m);
    result_t r;
    int sz, s, ev, fr;
    bit found, gone;
    r = '0;
    ev = 0;
    sz = (int'(sz_in) > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : int'(sz_in);
    if (op == REQ_ACQUIRE) begin
      if (!en) begin
        r.status = ST_DISABLED;
      end else begin
        found = 0;
        s = head;
        for (int i = 0; i < n_entries; i++) begin
          if (tag_ok[s] && tag_file[s] == f && tag_blk[s] == b && tag_size[s] >= sz) begin
            found = 1;
            break;
          end
          s = nxt[s];
        end
        if (found) begin
          r.hit = 1'b1;
          r.slot = SLOT_W'(s);
          if (tag_use[s] != 0) begin
            r.status = ST_BUSY;
          end else begin
            if (s != head) begin
              unlink(s);
              push_head(s);
            end
            tag_use[s] = 1;
          end
          r.use_cnt = USE_W'(tag_use[s]);
          r.flags = tag_flags[s];
        end else begin
          if (n_bytes + sz > byt_hi || n_entries + 1 >= ent_hi) ev = trim_to_low();
          fr = 0;
          while (fr < NS && tag_ok[fr]) fr++;
          if (fr >= NS) begin
            r.status = ST_NO_SLOT;
          end else begin
            tag_file[fr] = f;
            tag_blk[fr] = b;
            tag_size[fr] = sz;
            tag_use[fr] = 1;
            tag_flags[fr] = m;
            push_head(fr);
            tag_ok[fr] = 1'b1;
            n_entries++;
            n_bytes += sz;
            r.slot = SLOT_W'(fr);
            r.use_cnt = USE_W'(1);
            r.flags = m;
          end
        end
      end
    end else if (op >= REQ_REF && op <= REQ_TOUCH) begin
      r.slot = sl;
      s = int'(sl);
      if (!tag_ok[s]) begin
        r.status = ST_BAD_SLOT;
      end else begin
        gone = 0;
        case (op)
          REQ_REF: begin
            if (tag_use[s] >= 255) r.status = ST_USE_ERR; else tag_use[s]++;
          end
          REQ_RELEASE: begin
            if (tag_use[s] == 0) begin
              r.status = ST_USE_ERR;
            end else begin
              tag_use[s]--;
              ev = trim_to_low();
              gone = !tag_ok[s];
            end
          end
          REQ_INVALIDATE: begin
            if (tag_use[s] > 1) begin
              r.status = ST_BUSY;
            end else begin
              drop(s);
              ev = 1;
              gone = 1;
            end
          end
          REQ_SET_FLAGS: tag_flags[s] |= m;
          REQ_CLR_FLAGS: tag_flags[s] &= ~m;
          default: begin
            if (s != head) begin
              unlink(s);
              push_head(s);
            end
          end
        endcase
        if (!gone) begin
          r.use_cnt = USE_W'(tag_use[s]);
          r.flags = tag_flags[s];
        end
      end
    end else if (op == REQ_REM_FILE) begin
      ev = purge(0, f);
    end else if (op == REQ_REM_ALL) begin
      ev = purge(1, '0);
    end
    r.ev = (ev > 511) ? EV_W'(511) : EV_W'(ev);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t e, a;
    if (rst) begin
      en = 1'b1;
      ent_hi = ENTRIES_HIGH_RST;
      ent_lo = ENTRIES_LOW_RST;
      byt_hi = BYTES_HIGH_RST;
      byt_lo = BYTES_LOW_RST;
      for (int s = 0; s < NS; s++) tag_ok[s] = 1'b0;
      head = 0;
      tail = 0;
      n_entries = 0;
      n_bytes = 0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:     en = cfg_wdata[0];
          CFG_ENTRY_HIGH: ent_hi = cfg_wdata[EMARK_W-1:0];
          CFG_ENTRY_LOW:  ent_lo = cfg_wdata[EMARK_W-1:0];
          CFG_BYTE_HIGH:  byt_hi = cfg_wdata[BMARK_W-1:0];
          CFG_BYTE_LOW:   byt_lo = cfg_wdata[BMARK_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        expected_q.push_back(cache_step(req.req_type, req.file_id, req.phys_block,
                                        req.block_size, req.slot, req.flag_mask));
      if (rsp.valid && rsp.ready) begin
        a = '{rsp.status, rsp.hit, rsp.entry_slot, rsp.use_count_out, rsp.flags_out,
              rsp.evicted};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected response %h", $time, a);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (a !== e) begin
            $display("%0t: mismatch expected st=%0d hit=%0d slot=%0d use=%0d fl=%0d ev=%0d",
                     $time, e.status, e.hit, e.slot, e.use_cnt, e.flags, e.ev);
            $display("%0t:          actual   st=%0d hit=%0d slot=%0d use=%0d fl=%0d ev=%0d",
                     $time, a.status, a.hit, a.slot, a.use_cnt, a.flags, a.ev);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the buffer cache manager bench: clock, reset, register phases,
// directed and random requests with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFGI_W-1:0] cfg_index = '0;
  logic [CFGD_W-1:0] cfg_wdata = '0;
  int fail_count, pending;
  int slot_span;      // random slot numbers mostly fall at or below this
  bit rand_blocks;    // draw fresh 40-bit blocks, so most acquires miss
  bit hold_rsp;       // ask the response side for one long hold-off
  bit stim_done;
  int idle_cycles;

  lbcm_req_if req_ch();
  lbcm_rsp_if rsp_ch();

  lru_buffer_cache_manager DUT (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  lbcm_checker u_checker (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(logic [REQ_W-1:0] op, logic [FILE_W-1:0] f,
                           logic [BLOCK_W-1:0] b, logic [SIZE_W-1:0] sz,
                           logic [SLOT_W-1:0] sl, logic [FLAG_W-1:0] m);
    int g;
    g = pick_gap();
    repeat (g) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= op;
    req_ch.file_id <= f;
    req_ch.phys_block <= b;
    req_ch.block_size <= sz;
    req_ch.slot <= sl;
    req_ch.flag_mask <= m;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFGD_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain all outstanding items before touching the registers
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_marks(int eh, int el, int bh, int bl);
    settle();
    write_reg(CFG_ENTRY_HIGH, CFGD_W'(eh));
    write_reg(CFG_ENTRY_LOW, CFGD_W'(el));
    write_reg(CFG_BYTE_HIGH, CFGD_W'(bh));
    write_reg(CFG_BYTE_LOW, CFGD_W'(bl));
  endtask

  // one random request, weighted towards acquire and release
  task automatic random_item();
    int r;
    logic [REQ_W-1:0] op;
    logic [FILE_W-1:0] f;
    logic [BLOCK_W-1:0] b;
    logic [SIZE_W-1:0] sz;
    logic [SLOT_W-1:0] sl;
    r = $urandom_range(0, 99);
    if (r < 38) op = REQ_ACQUIRE;
    else if (r < 48) op = REQ_REF;
    else if (r < 68) op = REQ_RELEASE;
    else if (r < 75) op = REQ_INVALIDATE;
    else if (r < 81) op = REQ_SET_FLAGS;
    else if (r < 87) op = REQ_CLR_FLAGS;
    else if (r < 94) op = REQ_TOUCH;
    else if (r < 97) op = REQ_REM_FILE;
    else if (r < 98) op = REQ_REM_ALL;
    else op = REQ_W'($urandom_range(9, 15));
    // small file and block pools so that lookups hit
    if ($urandom_range(0, 9) == 0) f = FILE_W'($urandom);
    else f = $urandom_range(0, 3) == 3 ? 16'hFFFF : FILE_W'($urandom_range(0, 2));
    if (rand_blocks || $urandom_range(0, 9) == 0) b = BLOCK_W'({$urandom, $urandom});
    else b = BLOCK_W'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: sz = SIZE_W'(512);
      1: sz = SIZE_W'(4096);
      2: sz = SIZE_W'(65536);
      3: sz = SIZE_W'($urandom_range(1, 131071));
      default: sz = SIZE_W'($urandom_range(1, 16384));
    endcase
    if ($urandom_range(0, 19) == 0) sl = SLOT_W'($urandom);
    else sl = SLOT_W'($urandom_range(0, slot_span));
    send_item(op, f, b, sz, sl, FLAG_W'($urandom));
  endtask

  task automatic random_phase(int n);
    repeat (n) random_item();
  endtask

  // response side: random stalls, plus one long hold-off on request
  initial begin
    int g;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        for (int c = 0; c < 400; c++) @(negedge clk);
        hold_rsp = 1'b0;
      end
      g = pick_gap();
      if (g > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.file_id = '0;
    req_ch.phys_block = '0;
    req_ch.block_size = '0;
    req_ch.slot = '0;
    req_ch.flag_mask = '0;
    hold_rsp = 1'b0;
    stim_done = 1'b0;
    slot_span = 15;
    rand_blocks = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults written explicitly once
    write_reg(CFG_ENABLE, 1);
    set_marks(ENTRIES_HIGH_RST, ENTRIES_LOW_RST, BYTES_HIGH_RST, BYTES_LOW_RST);

    // directed: extremes, busy hit, underflow, every request code
    send_item(REQ_ACQUIRE, 16'hFFFF, '1, '1, 0, 3'h7);   // oversized, write-locked
    send_item(REQ_ACQUIRE, 16'hFFFF, '1, 1, 0, 0);       // hit while in use
    send_item(REQ_REF, 0, 0, 0, 0, 0);
    send_item(REQ_RELEASE, 0, 0, 0, 0, 0);
    send_item(REQ_RELEASE, 0, 0, 0, 0, 0);
    send_item(REQ_RELEASE, 0, 0, 0, 0, 0);               // underflow
    send_item(REQ_ACQUIRE, 16'hFFFF, '1, 65536, 0, 0);   // free hit
    send_item(REQ_REF, 0, 0, 0, 0, 0);
    send_item(REQ_INVALIDATE, 0, 0, 0, 0, 0);            // busy
    send_item(REQ_RELEASE, 0, 0, 0, 0, 0);
    send_item(REQ_INVALIDATE, 0, 0, 0, 0, 0);
    send_item(REQ_ACQUIRE, 0, 0, 1, 0, 0);
    send_item(REQ_ACQUIRE, 1, 5, 4096, 0, 3'h2);
    send_item(REQ_SET_FLAGS, 0, 0, 0, 1, 3'h5);
    send_item(REQ_CLR_FLAGS, 0, 0, 0, 1, 3'h1);
    send_item(REQ_TOUCH, 0, 0, 0, 0, 0);
    send_item(REQ_REF, 0, 0, 0, 8'hFF, 0);               // slot not valid
    send_item(4'hF, '1, '1, '1, 8'hFF, 3'h7);            // unknown code
    send_item(REQ_REM_FILE, 1, 0, 0, 0, 0);
    send_item(REQ_REM_ALL, 0, 0, 0, 0, 0);
    send_item(REQ_ACQUIRE, 2, 3, 512, 0, 0);
    // ref until the use count overflows
    repeat (256) send_item(REQ_REF, 0, 0, 0, 0, 0);
    send_item(REQ_REM_ALL, 0, 0, 0, 0, 0);

    // tight marks; long response hold-off fills the block up
    set_marks(8, 4, 300000, 150000);
    hold_rsp = 1'b1;
    random_phase(300);

    // extreme low marks: every miss evicts all it can
    set_marks(1, 0, 1, 0);
    random_phase(200);

    // extreme high marks: fill every slot until no free slot
    set_marks(256, 256, 16777216, 16777216);
    slot_span = 255;
    rand_blocks = 1'b1;
    random_phase(400);
    rand_blocks = 1'b0;

    // disabled cache
    settle();
    write_reg(CFG_ENABLE, 0);
    random_phase(100);
    settle();
    write_reg(CFG_ENABLE, 1);

    // byte budget is the binding limit
    set_marks(ENTRIES_HIGH_RST, ENTRIES_LOW_RST, 200000, 100000);
    slot_span = 63;
    random_phase(250);

    // byte low mark zero: eviction runs until blocked
    set_marks(20, 10, 16777216, 0);
    slot_span = 31;
    random_phase(200);

    settle();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> lru_buffer_cache_manager.f
hw/rtl/lbcm_pkg.sv
hw/rtl/lbcm_if.sv
hw/rtl/lbcm_ram.sv
hw/rtl/lru_buffer_cache_manager.sv
dv/lbcm_checker.sv
dv/tb.sv
